[rtl/vector3_normalize_macros.svh]
// Assertion macros shared by the vector normaliser RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define V3N_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Expression must never be true.
`define V3N_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[rtl/v3n_pkg.sv]
// Types and constants for the vector normaliser.
// No dependencies; used by the top-level vector3_normalize module and the bench.
`timescale 1ns / 1ps
`default_nettype none
package v3n_pkg;

   localparam int ADDR_W = 3;

   // Register index, taken from paddr[2].
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_MODE      = 1'b1;

   localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

   typedef struct packed {
      logic signed [31:0] comp_x;
      logic signed [31:0] comp_y;
      logic signed [31:0] comp_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] unit_x;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_z;
      logic        [31:0] length;
      logic               is_small;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
   } sqrt_side_type;

   typedef struct packed {
      logic [31:0]      len;
      logic             below_tol;
      logic [2:0]       neg;
      logic [2:0][30:0] pass;
   } div_side_type;

endpackage
`default_nettype wire

[rtl/v3n_isqrt.sv]
// Pipelined integer square root of a 64-bit value, two radicand bits per stage.
// Depends on nothing; side-band data travels alongside each operand.
`timescale 1ns / 1ps
`default_nettype none
module v3n_isqrt #(
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [63:0]   in_value,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [31:0]        out_root,
   output logic [SW-1:0]      out_side
);

   localparam int STAGES = 32;

   logic [STAGES:0]         valid_ff;
   logic [33:0]             rem_ff  [0:STAGES];
   logic [31:0]             root_ff [0:STAGES];
   logic [63:0]             val_ff  [0:STAGES];
   logic [SW-1:0]           side_ff [0:STAGES];

   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign val_ff[0]   = in_value;
   assign side_ff[0]  = in_side;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [35:0] rem_t;
      logic [35:0] trial;
      logic        take;
      logic [33:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         rem_t   = {rem_ff[k], val_ff[k][63:62]};
         trial   = {2'b00, root_ff[k], 2'b01};
         take    = rem_t >= trial;
         rem_in  = take ? 34'(rem_t - trial) : rem_t[33:0];
         root_in = {root_ff[k][30:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         val_ff[k+1]  <= {val_ff[k][61:0], 2'b00};
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_root  = root_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule
`default_nettype wire

[rtl/v3n_udiv.sv]
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Each dividend must be below divisor * 2^31; side-band data rides along.
`timescale 1ns / 1ps
`default_nettype none
module v3n_udiv #(
   parameter int SW = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [2:0][62:0] in_num,
   input  wire logic [31:0]      in_den,
   input  wire logic [SW-1:0]    in_side,
   output logic                  out_valid,
   output logic [2:0][30:0]      out_quo,
   output logic [SW-1:0]         out_side
);

   localparam int STAGES = 31;

   logic [STAGES:0]  valid_ff;
   logic [2:0][31:0] rem_ff  [0:STAGES];
   logic [2:0][30:0] low_ff  [0:STAGES];
   logic [2:0][30:0] quo_ff  [0:STAGES];
   logic [31:0]      den_ff  [0:STAGES];
   logic [SW-1:0]    side_ff [0:STAGES];

   assign valid_ff[0] = in_valid;
   assign den_ff[0]   = in_den;
   assign side_ff[0]  = in_side;
   for (genvar l = 0; l < 3; l++) begin : g_init
      assign rem_ff[0][l] = in_num[l][62:31];
      assign low_ff[0][l] = in_num[l][30:0];
      assign quo_ff[0][l] = '0;
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [2:0][31:0] rem_in;
      logic [2:0][30:0] quo_in;

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            logic [32:0] rem_t;
            logic        take;
            rem_t     = {rem_ff[k][l], low_ff[k][l][30]};
            take      = rem_t >= {1'b0, den_ff[k]};
            rem_in[l] = take ? 32'(rem_t - {1'b0, den_ff[k]}) : rem_t[31:0];
            quo_in[l] = {quo_ff[k][l][29:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1]  <= rem_in;
         quo_ff[k+1]  <= quo_in;
         for (int l = 0; l < 3; l++) begin
            low_ff[k+1][l] <= {low_ff[k][l][29:0], 1'b0};
         end
         den_ff[k+1]  <= den_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign out_quo   = quo_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule
`default_nettype wire

[rtl/vector3_normalize.sv]
// Vector normaliser: the path from the accepting edge to the result strobe is
// made up of 3 input stages, the 32-stage square root, 1 set-up stage, the 31-stage
// divider and the output register; every stage is pipelined, so one vector per cycle.
// busy is never raised and the receiver cannot stall, so a transfer is taken every cycle.
// Synchronous reset clears the pipeline valid bits and sets the tolerance to 1, mode to 0.
// Depends on v3n_pkg, v3n_isqrt, v3n_udiv and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_normalize_macros.svh"
module vector3_normalize import v3n_pkg::*; #(
   parameter int IN_FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int          SHIFT     = 30 - IN_FRAC_BITS;
   localparam logic [31:0] PASS_LIM  = 32'(1) << IN_FRAC_BITS;

   // Configuration registers.
   logic [15:0] tol_ff;
   logic        mode_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff  <= 16'd1;
         mode_ff <= 1'b0;
      end else if (wr_en) begin
         case (paddr[2])
            REG_TOLERANCE: tol_ff  <= pwdata[15:0];
            REG_MODE:      mode_ff <= pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_TOLERANCE: prdata = {16'd0, tol_ff};
         REG_MODE:      prdata = {31'd0, mode_ff};
         default:       prdata = '0;
      endcase
   end

   assign busy = 1'b0;

   // Stage 1: magnitudes and signs.
   logic          s1_valid_ff;
   sqrt_side_type s1_ff;
   logic [2:0][31:0] comp;

   assign comp = {req_data.comp_x, req_data.comp_y, req_data.comp_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      for (int l = 0; l < 3; l++) begin
         s1_ff.neg[l] <= comp[l][31];
         s1_ff.mag[l] <= comp[l][31] ? 32'(-comp[l]) : comp[l];
      end
   end

   // Stage 2: squares.
   logic             s2_valid_ff;
   sqrt_side_type    s2_ff;
   logic [2:0][63:0] sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ff <= s1_ff;
      for (int l = 0; l < 3; l++) begin
         sq_ff[l] <= 64'(s1_ff.mag[l]) * 64'(s1_ff.mag[l]);
      end
   end

   // Stage 3: sum of squares, exact in 64 bits.
   logic          s3_valid_ff;
   sqrt_side_type s3_ff;
   logic [63:0]   sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_ff  <= s2_ff;
      sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   logic          sq_valid;
   logic [31:0]   sq_root;
   sqrt_side_type sq_side;

   v3n_isqrt #(.SW($bits(sqrt_side_type))) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_value  (sum_ff),
      .in_side   (s3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Dividend set-up: |c| * 2^30 + len/2 gives round half away from zero.
   // The square root of a sum of 32-bit squares stays below 2^32, so no saturation.
   logic             d0_valid_ff;
   div_side_type     d0_ff;
   logic [2:0][62:0] num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else begin
         d0_valid_ff <= sq_valid;
      end
      d0_ff.len       <= sq_root;
      d0_ff.below_tol <= sq_root <= {16'd0, tol_ff};
      d0_ff.neg       <= sq_side.neg;
      for (int l = 0; l < 3; l++) begin
         num_ff[l] <= 63'({sq_side.mag[l], 30'd0}) + 63'(sq_root[31:1]);
         if (sq_side.mag[l] > PASS_LIM) begin
            d0_ff.pass[l] <= UNIT_ONE;
         end else begin
            d0_ff.pass[l] <= 31'(sq_side.mag[l] << SHIFT);
         end
      end
   end

   logic             dv_valid;
   logic [2:0][30:0] dv_quo;
   div_side_type     dv_side;

   v3n_udiv #(.SW($bits(div_side_type))) u_udiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d0_valid_ff),
      .in_num    (num_ff),
      .in_den    (d0_ff.len),
      .in_side   (d0_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Output stage: pick the small-vector result, clamp, apply sign.
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic [2:0][31:0] unit_in;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic [30:0] m;
         if (dv_side.below_tol) begin
            m = mode_ff ? dv_side.pass[l] : 31'd0;
         end else begin
            m = (dv_quo[l] > UNIT_ONE) ? UNIT_ONE : dv_quo[l];
         end
         unit_in[l] = dv_side.neg[l] ? 32'(-{1'b0, m}) : {1'b0, m};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
      rsp_ff.unit_x   <= unit_in[2];
      rsp_ff.unit_y   <= unit_in[1];
      rsp_ff.unit_z   <= unit_in[0];
      rsp_ff.length   <= dv_side.len;
      rsp_ff.is_small <= dv_side.below_tol;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `V3N_ASSERT_NEVER(a_no_busy, busy, "busy raised although the pipeline never stalls")
   `V3N_ASSERT_IMP(a_small_flag, rsp_valid && !rsp_data.is_small,
      rsp_data.length > {16'd0, tol_ff}, "length at or below tolerance without small flag")
   `V3N_ASSERT_IMP(a_small_zero, rsp_valid && rsp_data.is_small && !mode_ff,
      rsp_data.unit_x == 0 && rsp_data.unit_y == 0 && rsp_data.unit_z == 0,
      "small vector in zero mode gave a non-zero unit vector")

endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the vector normaliser: directed and random vectors,
// predicted in the bench and checked field by field. Depends on v3n_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
   import v3n_pkg::*;

   localparam int LATENCY = 68;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   vector3_normalize dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench copy of the registers.
   logic [15:0] tol_reg = 16'd1;
   logic mode_reg = 1'b0;

   req_type pending_vecs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int checked = 0;
   int small_seen = 0;
   bit quiet_phase = 0;
   bit hold_send = 0;
   int gap = 0;

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] apply_sign(logic [63:0] mag, logic neg);
      if (mag > 64'h4000_0000) mag = 64'h4000_0000;
      return neg ? 32'(-mag) : mag[31:0];
   endfunction

   function automatic rsp_type normalise(req_type v);
      rsp_type r;
      logic [31:0] c[3];
      logic [63:0] a[3], sum, len, m;
      logic neg[3];
      logic [31:0] u[3];
      c[0] = v.comp_x; c[1] = v.comp_y; c[2] = v.comp_z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i][31];
         a[i] = neg[i] ? (64'h1_0000_0000 - c[i]) : {32'd0, c[i]};
         sum += a[i] * a[i];
      end
      len = root_floor(sum);
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
      r.is_small = len <= {48'd0, tol_reg};
      for (int i = 0; i < 3; i++) begin
         if (r.is_small) begin
            if (!mode_reg) m = 0;
            else if (a[i] > 64'h1_0000) m = 64'h4000_0000;
            else m = a[i] << 14;
         end else begin
            m = ((a[i] << 30) + (len >> 1)) / len;
         end
         u[i] = apply_sign(m, neg[i]);
      end
      r.unit_x = u[0]; r.unit_y = u[1]; r.unit_z = u[2];
      r.length = len[31:0];
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // Driver: one transfer per cycle while vectors are pending and sending is not held, unless idling is under way.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(normalise(req_data));
         end
         if (start && busy) begin
            // hold the offered item
         end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
         end else if (!hold_send && pending_vecs.size() > 0) begin
            if (!quiet_phase && $urandom_range(0, 9) == 0) begin
               gap <= $urandom_range(0, 6);
               start <= 1'b0;
            end else begin
               req_data <= pending_vecs.pop_front();
               start <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("result with nothing expected");
            errors++;
         end else begin
            rsp_type w;
            w = expected_rsps.pop_front();
            if (rsp_data.unit_x !== w.unit_x) report("unit_x", rsp_data.unit_x, w.unit_x);
            if (rsp_data.unit_y !== w.unit_y) report("unit_y", rsp_data.unit_y, w.unit_y);
            if (rsp_data.unit_z !== w.unit_z) report("unit_z", rsp_data.unit_z, w.unit_z);
            if (rsp_data.length !== w.length) report("length", rsp_data.length, w.length);
            if (rsp_data.is_small !== w.is_small)
               report("is_small", rsp_data.is_small, w.is_small);
            checked++;
            if (w.is_small) small_seen++;
         end
      end
   end

   task automatic csr_write(int idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'(idx * 4); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == 0) tol_reg = val[15:0];
      else mode_reg = val[0];
   endtask

   task automatic wait_drained();
      while (pending_vecs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 8)) - 4);
         2: return 32'($signed($urandom_range(0, 400)) - 200);
         3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         4: return 32'($signed($urandom_range(0, 131072)) - 65536);
         default: return $urandom() >>> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic add_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type v;
      v.comp_x = x; v.comp_y = y; v.comp_z = z;
      pending_vecs.push_back(v);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Directed: zero, extremes, equal to tolerance, just above it.
      add_vec(0, 0, 0);
      add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vec(32'h8000_0000, 0, 0);
      add_vec(1, 0, 0);
      add_vec(0, -1, 0);
      add_vec(0, 0, 2);
      add_vec(32'h0001_0000, 32'hFFFF_0000, 0);
      add_vec(-3, 4, 0);
      add_vec(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h7FFF_0000);
      wait_drained();
      csr_write(1, 1);
      csr_write(0, 16'hFFFF);
      add_vec(32'h0000_FFFF, 0, 0);
      add_vec(32'hFFFF_0001, 0, 0);
      add_vec(32'h0001_0000, 0, 0);
      add_vec(32'h0001_0001, 0, 0);
      add_vec(-100, 200, -300);
      add_vec(0, 0, 0);
      wait_drained();
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(0, ph == 0 ? 32'd0 : ph == 1 ? 32'hFFFF : $urandom());
         csr_write(1, ph % 2);
         if (ph == 3) begin
            hold_send = 1;
            for (int i = 0; i < 30; i++)
               add_vec(rand_comp(), rand_comp(), rand_comp());
            hold_send = 0;
            while (pending_vecs.size() > 15) @(posedge clock);
            hold_send = 1;
            while (start || expected_rsps.size() > 0) @(posedge clock);
            hold_send = 0;
         end
         if (ph == 5) quiet_phase = 1;
         for (int i = 0; i < 90; i++)
            add_vec(rand_comp(), rand_comp(), rand_comp());
         wait_drained();
      end
      $display("checked %0d normalised vectors, %0d of them small, over eight settings",
               checked, small_seen);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
